>>> sv/dss_pkg.sv
package dss_pkg;

  // Register map: register index is paddr[3], 64-bit registers at 8-byte spacing
  localparam logic RegDelimBytes  = 1'b0;
  localparam logic RegDelimLength = 1'b1;

  localparam int unsigned DelimWidth = 64;
  localparam int unsigned LenWidth   = 4;

  localparam logic [DelimWidth-1:0] DelimBytesReset  = 64'd44;
  localparam logic [LenWidth-1:0]   DelimLengthReset = 4'd1;

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_has_byte;
    logic       in_string_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       segment_done;
    logic       string_done;
    logic       run_last;
  } out_item_t;

  // Closing flags of one queued job
  typedef struct packed {
    logic seg_mid;   // segment end after the byte results
    logic str_end;   // final segment end of the string
  } job_ctl_t;

endpackage

>>> sv/dss_front.sv
module dss_front
  import dss_pkg::*;
#(
  parameter int unsigned MaxDelim = 8,
  localparam int unsigned CW = $clog2(MaxDelim + 2),
  localparam int unsigned SN = MaxDelim + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  input  logic [DelimWidth-1:0] delim_bytes_i,
  input  logic [LenWidth-1:0]   delim_len_i,
  output logic                  job_valid_o,
  input  logic                  job_full_i,
  output logic [SN-1:0][7:0]    job_bytes_o,
  output logic [CW-1:0]         job_nb_o,
  output job_ctl_t              job_ctl_o
);

  logic [MaxDelim-1:0][7:0] win_q, win_d;
  logic [CW-1:0]            fill_q, fill_d;

  logic                     accept;
  logic                     has_byte;
  logic                     str_end;
  logic [CW-1:0]            len;
  logic [SN-1:0][7:0]       seq;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            pre_pops;
  logic [CW-1:0]            kept;
  logic                     full_win;
  logic [MaxDelim-1:0][7:0] aligned;
  logic                     mismatch;
  logic                     seg_mid;
  logic [CW-1:0]            mid_pops;
  logic [CW-1:0]            nb;

  assign accept     = in_valid_i && !job_full_i;
  assign in_stall_o = job_full_i;
  assign has_byte   = in_data_i.in_has_byte;
  assign str_end    = in_data_i.in_string_end;

  // Saturate the configured length
  assign len = (delim_len_i > LenWidth'(MaxDelim)) ? CW'(MaxDelim) : CW'(delim_len_i);

  // Held bytes followed by the new byte, oldest first
  always_comb begin
    seq = '0;
    for (int k = 0; k < MaxDelim; k++) begin
      seq[k] = win_q[k];
    end
    for (int k = 0; k < SN; k++) begin
      if (int'(fill_q) == k) begin
        seq[k] = in_data_i.in_byte;
      end
    end
  end

  assign cnt      = fill_q + CW'(has_byte);
  // Bytes passed out before the new byte is taken (length lowered mid-string)
  assign pre_pops = (has_byte && fill_q >= len) ? (fill_q - len + CW'(1)) : '0;
  assign kept     = cnt - pre_pops;
  assign full_win = has_byte && (kept == len);

  // Window after the early pops, aligned to the delimiter
  always_comb begin
    for (int k = 0; k < MaxDelim; k++) begin
      aligned[k] = 8'd0;
      for (int j = 0; j < SN; j++) begin
        if (j == int'(pre_pops) + k) begin
          aligned[k] = seq[j];
        end
      end
    end
  end

  always_comb begin
    mismatch = 1'b0;
    for (int k = 0; k < MaxDelim; k++) begin
      if (k < int'(len) && aligned[k] != delim_bytes_i[8*k +: 8]) begin
        mismatch = 1'b1;
      end
    end
  end

  assign seg_mid  = full_win && !mismatch;
  assign mid_pops = pre_pops + CW'(full_win && mismatch);

  // String end flushes all held bytes, unless a match consumed them
  always_comb begin
    if (str_end) begin
      nb = seg_mid ? pre_pops : cnt;
    end else begin
      nb = mid_pops;
    end
  end

  // Next window state
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (accept) begin
      if (len == '0 || str_end || seg_mid) begin
        fill_d = '0;
      end else begin
        fill_d = cnt - mid_pops;
      end
      for (int k = 0; k < MaxDelim; k++) begin
        win_d[k] = 8'd0;
        for (int j = 0; j < SN; j++) begin
          if (j == int'(mid_pops) + k) begin
            win_d[k] = seq[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

  // Push a job only when the item causes at least one result
  assign job_valid_o       = accept && (len != '0) && (nb != '0 || seg_mid || str_end);
  assign job_bytes_o       = seq;
  assign job_nb_o          = nb;
  assign job_ctl_o.seg_mid = seg_mid;
  assign job_ctl_o.str_end = str_end;

endmodule

>>> sv/dss_queue.sv
module dss_queue
  import dss_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned PW = $clog2(Depth),
  localparam int unsigned NW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      count_q <= count_q + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

>>> sv/dss_back.sv
module dss_back
  import dss_pkg::*;
#(
  parameter int unsigned MaxDelim = 8,
  localparam int unsigned CW = $clog2(MaxDelim + 2),
  localparam int unsigned SN = MaxDelim + 1,
  localparam int unsigned IW = $clog2(MaxDelim + 4)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  logic [SN-1:0][7:0] job_bytes_i,
  input  logic [CW-1:0]      job_nb_i,
  input  job_ctl_t           job_ctl_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  logic [IW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, res;
  logic [IW-1:0] total;
  logic [IW-1:0] nb;
  logic          load;
  logic          last;
  logic [7:0]    sel_byte;

  assign nb    = IW'(job_nb_i);
  assign total = nb + IW'(job_ctl_i.seg_mid) + IW'(job_ctl_i.str_end);
  assign last  = (idx_q + IW'(1) == total);
  assign load  = job_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    sel_byte = 8'd0;
    for (int k = 0; k < SN; k++) begin
      if (int'(idx_q) == k) begin
        sel_byte = job_bytes_i[k];
      end
    end
  end

  // Current result of the head job: bytes, then mid segment end, then string end
  always_comb begin
    res          = '0;
    res.run_last = last;
    priority if (idx_q < nb) begin
      res.out_byte     = sel_byte;
      res.out_has_byte = 1'b1;
    end else if (idx_q == nb && job_ctl_i.seg_mid) begin
      res.segment_done = 1'b1;
    end else begin
      res.segment_done = 1'b1;
      res.string_done  = 1'b1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + IW'(1);
    end
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign job_pop_o   = load && last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/delimiter_stream_splitter.sv
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_stall_o       in_data_i  (in_item_t)
// out       output     out_valid_o / out_stall_i     out_data_o (out_item_t)
// config    input      APB psel/penable/pwrite       paddr, pwdata, prdata
//
// The front takes one item per cycle unless the job queue is full and updates the
// delimiter window in the same cycle; the back emits one result per cycle unless
// out_stall_i holds it, from a 4-entry job queue through the output register.
// Reset is asynchronous: delimiter ',' of length 1, empty window, queue empty.
// in_stall_o is high while the job queue is full; out_stall_i holds the
// output register and lets the queue fill.
module delimiter_stream_splitter
  import dss_pkg::*;
#(
  parameter int unsigned MAX_DELIM = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [DelimWidth-1:0] pwdata,
  output logic [DelimWidth-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW         = $clog2(MAX_DELIM + 2);
  localparam int unsigned SN         = MAX_DELIM + 1;
  localparam int unsigned JobWidth   = SN * 8 + CW + $bits(job_ctl_t);
  localparam int unsigned QueueDepth = 4;

  logic [DelimWidth-1:0] delim_bytes_q;
  logic [LenWidth-1:0]   delim_len_q;
  logic                  cfg_write;

  logic                  job_push;
  logic                  job_full;
  logic [SN-1:0][7:0]    push_bytes;
  logic [CW-1:0]         push_nb;
  job_ctl_t              push_ctl;
  logic                  head_valid;
  logic                  head_pop;
  logic [JobWidth-1:0]   head_data;
  logic [SN-1:0][7:0]    head_bytes;
  logic [CW-1:0]         head_nb;
  job_ctl_t              head_ctl;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_bytes_q <= DelimBytesReset;
      delim_len_q   <= DelimLengthReset;
    end else if (cfg_write) begin
      unique case (paddr[3])
        RegDelimBytes:  delim_bytes_q <= pwdata;
        RegDelimLength: delim_len_q   <= pwdata[LenWidth-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      RegDelimBytes:  prdata = delim_bytes_q;
      RegDelimLength: prdata = {{(DelimWidth - LenWidth){1'b0}}, delim_len_q};
      default:        prdata = '0;
    endcase
  end

  dss_front #(
    .MaxDelim (MAX_DELIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .delim_bytes_i (delim_bytes_q),
    .delim_len_i   (delim_len_q),
    .job_valid_o   (job_push),
    .job_full_i    (job_full),
    .job_bytes_o   (push_bytes),
    .job_nb_o      (push_nb),
    .job_ctl_o     (push_ctl)
  );

  dss_queue #(
    .Width (JobWidth),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({push_bytes, push_nb, push_ctl}),
    .full_o  (job_full),
    .valid_o (head_valid),
    .pop_i   (head_pop),
    .data_o  (head_data)
  );

  assign {head_bytes, head_nb, head_ctl} = head_data;

  dss_back #(
    .MaxDelim (MAX_DELIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_bytes_i (head_bytes),
    .job_nb_i    (head_nb),
    .job_ctl_i   (head_ctl),
    .job_pop_o   (head_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A job is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("job pushed into full queue");

  // A byte result never closes a segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_has_byte) |-> !out_data_o.segment_done)
    else $error("byte result also closes a segment");

  // The string end is a segment end and the last result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.string_done) |->
      (out_data_o.segment_done && out_data_o.run_last))
    else $error("string end not last segment end of its item");

endmodule

>>> test/delimiter_stream_splitter_tb.sv
`timescale 1ns / 1ps

module delimiter_stream_splitter_tb;
  import dss_pkg::*;

  localparam int unsigned MaxDelim      = 8;
  localparam int unsigned Items         = 250;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 20;

  // Expected segment stream, built from accepted bytes and the current delimiter
  class split_scoreboard;
    logic [7:0]            win [MaxDelim];
    int unsigned           fill;
    logic [DelimWidth-1:0] delim;
    logic [LenWidth-1:0]   dlen;
    out_item_t             pieces_due [$];
    int unsigned           errors;

    function new();
      delim  = DelimBytesReset;
      dlen   = DelimLengthReset;
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (win[k]) win[k] = 8'h00;
      fill = 0;
    endfunction

    function void set_reg(logic idx, logic [DelimWidth-1:0] val);
      if (idx == RegDelimBytes) delim = val;
      else dlen = val[LenWidth-1:0];
    endfunction

    // Append one expected result at the tail
    function void queue_piece(out_item_t piece);
      pieces_due.insert(pieces_due.size(), piece);
    endfunction

    // Shift the oldest window byte out as a segment byte
    function out_item_t pop_byte();
      out_item_t piece;
      piece = '{out_byte: win[0], out_has_byte: 1'b1, default: 1'b0};
      for (int k = 1; k < MaxDelim; k++) win[k-1] = win[k];
      win[MaxDelim-1] = 8'h00;
      if (fill > 0) fill--;
      return piece;
    endfunction

    function out_item_t seg_end(logic str_end);
      out_item_t piece;
      piece = '{out_byte: 8'h00, out_has_byte: 1'b0, segment_done: 1'b1,
                string_done: str_end, run_last: 1'b0};
      return piece;
    endfunction

    function void take_item(in_item_t it);
      int unsigned len;
      int unsigned start;
      bit          hit;
      start = pieces_due.size();
      len = (dlen > MaxDelim) ? MaxDelim : dlen;
      // zero length: item swallowed, held bytes dropped
      if (len == 0) begin
        clear_window();
        return;
      end
      if (it.in_has_byte) begin
        // a shorter length may leave too many bytes held
        while (fill >= len && fill > 0) queue_piece(pop_byte());
        if (fill < MaxDelim) begin
          win[fill] = it.in_byte;
          fill++;
        end
        if (fill == len) begin
          hit = 1'b1;
          for (int k = 0; k < len; k++)
            if (win[k] != delim[8*k +: 8]) hit = 1'b0;
          if (hit) begin
            queue_piece(seg_end(1'b0));
            clear_window();
          end else begin
            queue_piece(pop_byte());
          end
        end
      end
      // string end: flush the window, close the final segment
      if (it.in_string_end) begin
        while (fill > 0) queue_piece(pop_byte());
        queue_piece(seg_end(1'b1));
      end
      if (pieces_due.size() > start) pieces_due[$].run_last = 1'b1;
    endfunction

    function void check_piece(out_item_t got);
      out_item_t want;
      bit        bad;
      if (pieces_due.size() == 0) begin
        $display("%0t: nothing expected, got byte %h has %b seg %b str %b last %b",
                 $time, got.out_byte, got.out_has_byte, got.segment_done,
                 got.string_done, got.run_last);
        errors++;
        return;
      end
      want = pieces_due.pop_front();
      bad = (got.out_byte !== want.out_byte) || (got.out_has_byte !== want.out_has_byte) ||
            (got.segment_done !== want.segment_done) ||
            (got.string_done !== want.string_done) || (got.run_last !== want.run_last);
      if (bad) begin
        $display("%0t: expected %h/%b/%b/%b/%b, got %h/%b/%b/%b/%b (byte/has/seg/str/last)",
                 $time, want.out_byte, want.out_has_byte, want.segment_done,
                 want.string_done, want.run_last, got.out_byte, got.out_has_byte,
                 got.segment_done, got.string_done, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [3:0]            paddr       = '0;
  logic [DelimWidth-1:0] pwdata      = '0;
  logic [DelimWidth-1:0] prdata;
  logic                  pready;

  split_scoreboard       splits;
  int unsigned           in_xfers  = 0;
  int unsigned           sent      = 0;
  int unsigned           quiet     = 0;
  int unsigned           hold_left = 0;
  bit                    hold_go   = 1'b0;
  bit                    hold_used = 1'b0;
  bit                    calm      = 1'b0;
  logic [DelimWidth-1:0] cur_delim;
  logic [LenWidth-1:0]   cur_len;
  int unsigned           cur_eff;

  delimiter_stream_splitter #(
    .MAX_DELIM(MaxDelim)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // Monitor both channels; watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        splits.take_item(in_data_i);
        in_xfers++;
      end
      if (out_valid_o && !out_stall_i) splits.check_piece(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while calm
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 12);
    end
  end

  // One input transfer, with random gaps before it
  task automatic send(input logic [7:0] b, input logic h, input logic e);
    int unsigned target;
    while (!calm && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, in_has_byte: h, in_string_end: e};
    target = in_xfers + 1;
    do @(negedge clk_i); while (in_xfers < target);
    if (h || e) sent++;
  endtask

  // Stop sending, wait for all results, then let no-result items clear
  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (splits.pieces_due.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // Register write followed by a read-back
  task automatic reg_write(input logic idx, input logic [DelimWidth-1:0] val);
    logic [DelimWidth-1:0] mask;
    mask = (idx == RegDelimLength) ? {{(DelimWidth-LenWidth){1'b0}}, {LenWidth{1'b1}}} : '1;
    splits.set_reg(idx, val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) !== (val & mask)) begin
      $display("%0t: register %0d read expected %h, got %h", $time, idx, val & mask,
               prdata & mask);
      splits.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned quota;
    int unsigned r;
    logic [7:0]  b;
    string       pat;

    splits = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset delimiter ',' of length 1
    send(8'h00, 1'b1, 1'b0);
    send(8'h2C, 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b1);
    send(8'h3A, 1'b0, 1'b1);   // empty string: one empty segment
    send(8'hA5, 1'b0, 1'b0);   // neither byte nor end
    send(8'h2C, 1'b1, 1'b1);

    // "abc" with junk in unused delimiter bytes; leftmost match after a false start
    settle(DrainCycles);
    reg_write(RegDelimBytes, 64'hFFFF_FFFF_FF63_6261);
    reg_write(RegDelimLength, 64'd3);
    pat = "aabcab";
    for (int k = 0; k < pat.len(); k++) send(pat[k], 1'b1, 1'b0);

    // shrink to one byte with two bytes still held
    settle(DrainCycles);
    reg_write(RegDelimLength, 64'd1);
    send(8'h78, 1'b1, 1'b1);

    // longest delimiter, all ones
    settle(DrainCycles);
    reg_write(RegDelimBytes, '1);
    reg_write(RegDelimLength, 64'd8);
    for (int k = 0; k < 8; k++) send(8'hFF, 1'b1, k == 7);

    // zero length: no output at all
    settle(DrainCycles);
    reg_write(RegDelimLength, 64'd0);
    send(8'h71, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);

    // length above the maximum saturates
    settle(DrainCycles);
    reg_write(RegDelimBytes, '0);
    reg_write(RegDelimLength, 64'd15);
    send(8'h00, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);

    // Random phases: strings over a small alphabet with embedded delimiters
    phase = 0;
    while (sent < Items) begin
      r = $urandom_range(99);
      if (r < 6) cur_len = 4'd0;
      else if (r < 12) cur_len = 4'($urandom_range(15, 9));
      else if (r < 30) cur_len = 4'd8;
      else cur_len = 4'($urandom_range(8, 1));
      // the hold-off phase needs results to back up the queue
      if (phase == 2 && cur_len == 4'd0) cur_len = 4'd1;
      cur_eff = (cur_len > MaxDelim) ? MaxDelim : cur_len;
      for (int k = 0; k < 8; k++)
        cur_delim[8*k +: 8] = ($urandom_range(3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(8'h64, 8'h61));
      settle(DrainCycles);
      reg_write(RegDelimBytes, cur_delim);
      reg_write(RegDelimLength, {{(DelimWidth-LenWidth){1'b0}}, cur_len});
      calm = (phase == 1);
      if (phase == 2) hold_go = 1'b1;
      quota = (phase == 2) ? 40 : $urandom_range(30, 10);
      for (int i = 0; i < quota; i++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          send(8'($urandom), 1'b0, 1'b0);
        end else if (r < 14) begin
          send(8'($urandom), 1'b0, 1'b1);
        end else if (r < 34 && cur_eff > 0) begin
          for (int k = 0; k < cur_eff; k++) send(cur_delim[8*k +: 8], 1'b1, 1'b0);
        end else begin
          r = $urandom_range(99);
          if (r < 45 && cur_eff > 0) b = cur_delim[8*$urandom_range(cur_eff-1) +: 8];
          else if (r < 50) b = 8'h00;
          else if (r < 55) b = 8'hFF;
          else b = 8'($urandom);
          send(b, 1'b1, $urandom_range(99) < 8);
        end
      end
      phase++;
    end

    settle(40);
    if (splits.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dss_pkg.sv
sv/dss_front.sv
sv/dss_queue.sv
sv/dss_back.sv
sv/delimiter_stream_splitter.sv
test/delimiter_stream_splitter_tb.sv
